FILE: sv/gps_pkg.sv
`timescale 1ns / 1ps

package gps_pkg;

    // Serial command letters.
    localparam logic [7:0] CHR_DELAY = 8'h44;  // 'D'
    localparam logic [7:0] CHR_PULSE = 8'h50;  // 'P'
    localparam logic [7:0] CHR_GO    = 8'h47;  // 'G'

    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned POWER_OFF_W = 26;

    localparam logic [COUNT_W-1:0]     COUNT_RESET     = 32'd10000;
    localparam logic [POWER_OFF_W-1:0] POWER_OFF_RESET = 26'd6250000;

    // Register byte offsets (one 32-bit register).
    localparam logic [2:0] REG_POWER_OFF = 3'd0;

    typedef enum logic [1:0] {
        PM_IDLE  = 2'd0,
        PM_DELAY = 2'd1,
        PM_PULSE = 2'd2
    } parse_mode_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_OFF   = 3'd1,
        PH_WAIT  = 3'd2,
        PH_DELAY = 3'd3,
        PH_PULSE = 3'd4
    } phase_t;

    // Parser to sequencer: start request and the loaded timing values.
    typedef struct packed {
        logic               go;
        logic [COUNT_W-1:0] delay_count;
        logic [COUNT_W-1:0] pulse_count;
    } gps_cmd_t;

    // One result item, highest bit first in the packed order below.
    typedef struct packed {
        logic byte_dropped;
        logic busy_res;
        logic glitch_out;
        logic power_enable;
    } gps_result_t;

endpackage

FILE: sv/gps_cmd_parser.sv
`timescale 1ns / 1ps

module gps_cmd_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            byte_en,     // byte taken by the parser this cycle
    input  logic [7:0]      byte_value,
    output gps_pkg::gps_cmd_t cmd
);

    gps_pkg::parse_mode_t              mode_reg, mode_next;
    logic [1:0]                        index_reg, index_next;
    logic [gps_pkg::COUNT_W-1:0]       shift_reg, shift_next;
    logic [gps_pkg::COUNT_W-1:0]       delay_reg, delay_next;
    logic [gps_pkg::COUNT_W-1:0]       pulse_reg, pulse_next;
    logic                              go;

    always_comb begin
        mode_next  = mode_reg;
        index_next = index_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        pulse_next = pulse_reg;
        go         = 1'b0;
        if (byte_en) begin
            case (mode_reg)
                gps_pkg::PM_DELAY, gps_pkg::PM_PULSE: begin
                    // Value bytes arrive little-endian; any byte counts as data.
                    case (index_reg)
                        2'd0:    shift_next[7:0]   = shift_reg[7:0]   | byte_value;
                        2'd1:    shift_next[15:8]  = shift_reg[15:8]  | byte_value;
                        2'd2:    shift_next[23:16] = shift_reg[23:16] | byte_value;
                        default: shift_next[31:24] = shift_reg[31:24] | byte_value;
                    endcase
                    if (index_reg == 2'd3) begin
                        if (mode_reg == gps_pkg::PM_DELAY) begin
                            delay_next = shift_next;
                        end else begin
                            pulse_next = shift_next;
                        end
                        mode_next  = gps_pkg::PM_IDLE;
                        index_next = 2'd0;
                    end else begin
                        index_next = index_reg + 2'd1;
                    end
                end
                default: begin
                    mode_next  = gps_pkg::PM_IDLE;
                    index_next = 2'd0;
                    if (byte_value == gps_pkg::CHR_DELAY) begin
                        mode_next  = gps_pkg::PM_DELAY;
                        shift_next = '0;
                    end else if (byte_value == gps_pkg::CHR_PULSE) begin
                        mode_next  = gps_pkg::PM_PULSE;
                        shift_next = '0;
                    end else if (byte_value == gps_pkg::CHR_GO) begin
                        go = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= gps_pkg::PM_IDLE;
            index_reg <= 2'd0;
            shift_reg <= '0;
            delay_reg <= gps_pkg::COUNT_RESET;
            pulse_reg <= gps_pkg::COUNT_RESET;
        end else begin
            mode_reg  <= mode_next;
            index_reg <= index_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            pulse_reg <= pulse_next;
        end
    end

    // The start request is seen in the same cycle; the counts are the stored
    // ones, since a sequence never runs in the cycle that a byte is parsed.
    assign cmd.go          = go;
    assign cmd.delay_count = delay_reg;
    assign cmd.pulse_count = pulse_reg;

endmodule

FILE: sv/gps_sequencer.sv
`timescale 1ns / 1ps

module gps_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,          // one tick accepted
    input  logic                              byte_valid,
    input  logic                              trigger_level,
    input  logic [gps_pkg::POWER_OFF_W-1:0]   power_off_ticks,
    input  gps_pkg::gps_cmd_t                 cmd,
    output logic                              busy,          // sequence running now
    output gps_pkg::gps_result_t              result         // state after this tick
);

    gps_pkg::phase_t               phase_reg, phase_next;
    logic [gps_pkg::COUNT_W-1:0]   tick_reg, tick_next;
    logic                          power_reg, power_next;
    logic [gps_pkg::COUNT_W-1:0]   tick_inc;

    assign busy     = (phase_reg != gps_pkg::PH_IDLE);
    assign tick_inc = tick_reg + 32'd1;

    // Next state.
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        power_next = power_reg;
        case (phase_reg)
            gps_pkg::PH_IDLE: begin
                if (cmd.go) begin
                    phase_next = gps_pkg::PH_OFF;
                    tick_next  = '0;
                    power_next = 1'b0;
                end
            end
            gps_pkg::PH_OFF: begin
                // The tick that took 'G' already counts as one off tick.
                tick_next = tick_inc;
                if (tick_inc >= {{(gps_pkg::COUNT_W-gps_pkg::POWER_OFF_W){1'b0}},
                                 power_off_ticks}) begin
                    power_next = 1'b1;
                    phase_next = gps_pkg::PH_WAIT;
                    tick_next  = '0;
                end
            end
            gps_pkg::PH_WAIT: begin
                if (trigger_level) begin
                    tick_next = '0;
                    if (cmd.delay_count != '0) begin
                        phase_next = gps_pkg::PH_DELAY;
                    end else if (cmd.pulse_count != '0) begin
                        phase_next = gps_pkg::PH_PULSE;
                    end else begin
                        phase_next = gps_pkg::PH_IDLE;
                    end
                end
            end
            gps_pkg::PH_DELAY: begin
                tick_next = tick_inc;
                if (tick_inc >= cmd.delay_count) begin
                    tick_next  = '0;
                    phase_next = (cmd.pulse_count != '0) ? gps_pkg::PH_PULSE
                                                         : gps_pkg::PH_IDLE;
                end
            end
            gps_pkg::PH_PULSE: begin
                tick_next = tick_inc;
                if (tick_inc >= cmd.pulse_count) begin
                    tick_next  = '0;
                    phase_next = gps_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = gps_pkg::PH_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        result.power_enable = power_next;
        result.glitch_out   = (phase_next == gps_pkg::PH_PULSE);
        result.busy_res     = (phase_next != gps_pkg::PH_IDLE);
        result.byte_dropped = busy & byte_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gps_pkg::PH_IDLE;
            tick_reg  <= '0;
            power_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            power_reg <= power_next;
        end
    end

endmodule

FILE: sv/gps_out_stage.sv
`timescale 1ns / 1ps

module gps_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,       // new result from an accepted tick
    input  gps_pkg::gps_result_t result,
    output logic                 free,       // register empty or emptying now
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata
);

    logic                 valid_reg, valid_next;
    gps_pkg::gps_result_t data_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0000, data_reg};

endmodule

FILE: sv/glitch_pulse_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                       Contents
// -------   ---------  --------------------------  --------------------------------
// s_axis    in         tvalid tready tdata tuser   one clock tick: serial byte, trigger
// m_axis    out        tvalid tready tdata         one status word per tick
// apb       in/out     psel penable pwrite paddr   power_off_ticks at offset 0
//                      pwdata prdata pready
//
// Every tick transfer yields exactly one result transfer, offered in the cycle after acceptance.
// A new tick is accepted in every cycle; the only limit is the single output
// register, which must be empty or be emptied in the same cycle.
// aresetn is synchronous and active low; it restores the command parser, the
// sequencer (idle, target power off) and the power-off register to their defaults.
// When m_axis stalls with a result pending, s_axis_tready drops and no tick is lost.

module glitch_pulse_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] byte_value, [8] trigger_level, rest zero
    input  logic        s_axis_tuser,   // [0] byte_valid

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] power_enable, [1] glitch_out,
                                        // [2] busy_res, [3] byte_dropped, rest zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                              accept;
    logic                              out_free;
    logic                              busy;
    logic                              parse_en;
    logic [gps_pkg::POWER_OFF_W-1:0]   power_off_reg;
    logic                              reg_sel;
    gps_pkg::gps_cmd_t                 cmd;
    gps_pkg::gps_result_t              result;

    // Configuration register. Bit 2 of the address picks the register; the low
    // two bits address bytes within the word and are ignored.
    assign pready  = 1'b1;
    assign reg_sel = ({paddr[2], 2'b00} == gps_pkg::REG_POWER_OFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_off_reg <= gps_pkg::POWER_OFF_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            power_off_reg <= pwdata[gps_pkg::POWER_OFF_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32-gps_pkg::POWER_OFF_W){1'b0}}, power_off_reg} : 32'd0;

    // A tick transfer is accepted whenever the output register can take its result.
    assign s_axis_tready = out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Bytes reach the parser only while no sequence runs; otherwise they are
    // dropped and flagged in the result.
    assign parse_en = accept && s_axis_tuser && !busy;

    gps_cmd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (parse_en),
        .byte_value (s_axis_tdata[7:0]),
        .cmd        (cmd)
    );

    gps_sequencer u_sequencer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (accept),
        .byte_valid      (s_axis_tuser),
        .trigger_level   (s_axis_tdata[8]),
        .power_off_ticks (power_off_reg),
        .cmd             (cmd),
        .busy            (busy),
        .result          (result)
    );

    gps_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
